[sv/cfe_pkg.sv]
// cfe_pkg: shared types, sizes and helpers for the conv2d forward engine
// no dependencies; imported by conv2d_forward_engine

package cfe_pkg;

	localparam int MaxInCh   = 16;
	localparam int MaxOutCh  = 16;
	localparam int MaxKernel = 5;
	localparam int MaxHeight = 32;
	localparam int MaxWidth  = 32;

	localparam int WDepth = MaxOutCh * MaxInCh * MaxKernel * MaxKernel;
	localparam int BDepth = MaxOutCh;
	localparam int SDepth = MaxInCh * MaxHeight * MaxWidth;

	localparam int WAddrW = $clog2(WDepth);
	localparam int SAddrW = $clog2(SDepth);

	typedef enum logic [1:0] {
		CMD_WEIGHT  = 2'd0,
		CMD_BIAS    = 2'd1,
		CMD_SAMPLE  = 2'd2,
		CMD_COMPUTE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_IN_CH  = 3'd0,
		REG_OUT_CH = 3'd1,
		REG_KERNEL = 3'd2,
		REG_STRIDE = 3'd3,
		REG_PAD    = 3'd4,
		REG_HEIGHT = 3'd5,
		REG_WIDTH  = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// saturate a 32-bit word to q8.8 range
	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) r = 16'sh7fff;
		else if (v < -32'sd32768) r = 16'sh8000;
		else r = v[15:0];
		return r;
	endfunction

endpackage

[sv/conv2d_forward_engine.sv]
// conv2d_forward_engine: direct 2d convolution, one output element per compute beat
// depends on cfe_pkg (sizes, command codes, state type, saturation helper)
//
// Usage: the input channel carries a command with address, value and the selected
// output position. Weight, bias and sample writes update the stores on acceptance and give no
// result. A compute beat reads the bias, then walks input channels and kernel taps
// with one shared 16x16 multiplier and a 48-bit accumulator, one tap per cycle
// (taps in the zero border are still stepped through but add nothing). The tap
// rate is set by the single weight/sample memory port pair feeding the multiplier.
// in_ready is high only while the sequencer is idle. Results sit in an output
// register; while it waits on out_ready further loads are still accepted, and a
// following compute runs but holds its result until the register is free.
// Positions outside the output map or on an unused channel return status 1 and a
// zero value. Reset clears control state and sets the registers to their
// defaults; store contents are undefined until written.
// Config writes (cfg_we, cfg_index, cfg_wdata) take effect at once and must only
// be issued while the block is idle.

module conv2d_forward_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [5:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [13:0]        address,
	input  logic signed [31:0] value,
	input  logic [3:0]         sel_channel,
	input  logic [4:0]         sel_row,
	input  logic [4:0]         sel_col,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] result_value,
	output logic [3:0]         result_channel,
	output logic [4:0]         result_row,
	output logic [4:0]         result_col,
	output logic               status
);
	import cfe_pkg::*;

	// configuration registers
	logic [4:0] in_ch_q, out_ch_q;
	logic [2:0] kernel_q, stride_q, pad_q;
	logic [5:0] height_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch_q  <= 5'd1;
			out_ch_q <= 5'd1;
			kernel_q <= 3'd3;
			stride_q <= 3'd1;
			pad_q    <= 3'd0;
			height_q <= 6'd32;
			width_q  <= 6'd32;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_IN_CH:  in_ch_q  <= cfg_wdata[4:0];
				REG_OUT_CH: out_ch_q <= cfg_wdata[4:0];
				REG_KERNEL: kernel_q <= cfg_wdata[2:0];
				REG_STRIDE: stride_q <= cfg_wdata[2:0];
				REG_PAD:    pad_q    <= cfg_wdata[2:0];
				REG_HEIGHT: height_q <= cfg_wdata[5:0];
				REG_WIDTH:  width_q  <= cfg_wdata[5:0];
				default: ;
			endcase
		end
	end

	// clamped views of the registers
	logic [4:0] ic_n, oc_n;
	logic [2:0] k, s;
	logic [5:0] h, w;
	always_comb begin
		ic_n = (in_ch_q == 5'd0) ? 5'd1 : (in_ch_q > 5'(MaxInCh)) ? 5'(MaxInCh) : in_ch_q;
		oc_n = (out_ch_q == 5'd0) ? 5'd1 :
			(out_ch_q > 5'(MaxOutCh)) ? 5'(MaxOutCh) : out_ch_q;
		k = (kernel_q == 3'd0) ? 3'd1 :
			(kernel_q > 3'(MaxKernel)) ? 3'(MaxKernel) : kernel_q;
		s = (stride_q == 3'd0) ? 3'd1 : stride_q;
		h = (height_q == 6'd0) ? 6'd1 :
			(height_q > 6'(MaxHeight)) ? 6'(MaxHeight) : height_q;
		w = (width_q == 6'd0) ? 6'd1 :
			(width_q > 6'(MaxWidth)) ? 6'(MaxWidth) : width_q;
	end

	// stores
	logic signed [15:0] weight_mem [WDepth];
	logic signed [15:0] sample_mem [SDepth];
	logic signed [31:0] bias_mem   [BDepth];

	state_t state_q, state_d;
	logic   in_acc;
	assign in_acc = in_valid && in_ready;

	// sequencer registers
	logic [3:0]         oc_q;
	logic [4:0]         row_q, col_q;
	logic [4:0]         ic_q;
	logic [2:0]         kh_q, kw_q;
	logic signed [9:0]  ih_q, iw_q, ih0_q, iw0_q;
	logic [WAddrW-1:0]  wa_q;
	logic [SAddrW-1:0]  plane_q;
	logic [10:0]        hw_q;
	logic               bad_q;
	logic signed [47:0] acc_q;

	// pipeline: memory read, multiply, accumulate
	logic               vld_s1, vld_s2;
	logic signed [15:0] wt_s1, smp_s1;
	logic signed [31:0] prod_s2;

	// tap qualification and sample address
	logic              tap_ok;
	logic [SAddrW-1:0] saddr;
	logic              last_kw, last_kh, last_ic;
	always_comb begin
		tap_ok = !ih_q[9] && (ih_q[8:0] < {3'd0, h}) && !iw_q[9] && (iw_q[8:0] < {3'd0, w});
		saddr = plane_q + SAddrW'(ih_q[4:0] * w) + SAddrW'(iw_q[4:0]);
		last_kw = (kw_q == k - 3'd1);
		last_kh = (kh_q == k - 3'd1);
		last_ic = (ic_q == ic_n - 5'd1);
	end

	// setup checks on the selected position
	logic [8:0] row_end, col_end;
	logic [6:0] span_h, span_w;
	logic       bad_pos;
	always_comb begin
		row_end = 9'(row_q * s) + 9'(k);
		col_end = 9'(col_q * s) + 9'(k);
		span_h  = 7'(h) + 7'({pad_q, 1'b0});
		span_w  = 7'(w) + 7'({pad_q, 1'b0});
		bad_pos = ({1'b0, oc_q} >= oc_n) || (row_end > 9'(span_h)) || (col_end > 9'(span_w));
	end

	logic out_free;
	assign out_free = !out_valid || out_ready;

	// next state and handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && cmd_t'(command) == CMD_COMPUTE) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = bad_pos ? ST_DONE : ST_RUN;
			ST_RUN: if (last_kw && last_kh && last_ic) state_d = ST_DRAIN;
			ST_DRAIN: if (!vld_s1 && !vld_s2) state_d = ST_DONE;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// store writes
	always_ff @(posedge clk) begin
		if (in_acc && cmd_t'(command) == CMD_WEIGHT && address < 14'(WDepth))
			weight_mem[address[WAddrW-1:0]] <= sat16(value);
		if (in_acc && cmd_t'(command) == CMD_SAMPLE)
			sample_mem[address[SAddrW-1:0]] <= sat16(value);
		if (in_acc && cmd_t'(command) == CMD_BIAS && address < 14'(BDepth))
			bias_mem[address[3:0]] <= value;
	end

	// registered memory reads
	always_ff @(posedge clk) begin
		wt_s1  <= weight_mem[wa_q];
		smp_s1 <= sample_mem[saddr];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= wt_s1 * smp_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= (state_q == ST_RUN) && tap_ok;
			vld_s2 <= vld_s1;
		end
	end

	// sequencer datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			oc_q  <= sel_channel;
			row_q <= sel_row;
			col_q <= sel_col;
		end
		case (state_q)
			ST_SETUP: begin
				bad_q   <= bad_pos;
				ic_q    <= 5'd0;
				kh_q    <= 3'd0;
				kw_q    <= 3'd0;
				wa_q    <= WAddrW'(8'(oc_q * ic_n) * 5'(k * k));
				plane_q <= '0;
				hw_q    <= 11'(h * w);
				ih0_q   <= $signed({2'b00, 8'(row_q * s)}) - $signed({7'd0, pad_q});
				iw0_q   <= $signed({2'b00, 8'(col_q * s)}) - $signed({7'd0, pad_q});
				ih_q    <= $signed({2'b00, 8'(row_q * s)}) - $signed({7'd0, pad_q});
				iw_q    <= $signed({2'b00, 8'(col_q * s)}) - $signed({7'd0, pad_q});
			end
			ST_RUN: begin
				wa_q <= wa_q + WAddrW'(1);
				if (!last_kw) begin
					kw_q <= kw_q + 3'd1;
					iw_q <= iw_q + 10'sd1;
				end else begin
					kw_q <= 3'd0;
					iw_q <= iw0_q;
					if (!last_kh) begin
						kh_q <= kh_q + 3'd1;
						ih_q <= ih_q + 10'sd1;
					end else begin
						kh_q    <= 3'd0;
						ih_q    <= ih0_q;
						ic_q    <= ic_q + 5'd1;
						plane_q <= plane_q + SAddrW'(hw_q);
					end
				end
			end
			default: ;
		endcase
	end

	// accumulator keeps the last exact sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_q <= '0;
		else if (state_q == ST_SETUP && !bad_pos) acc_q <= 48'(bias_mem[oc_q]);
		else if (vld_s2) acc_q <= acc_q + 48'(prod_s2);
	end

	// saturated result
	logic signed [31:0] sat_val;
	always_comb begin
		if (acc_q > 48'sh0000_7fff_ffff) sat_val = 32'sh7fff_ffff;
		else if (acc_q < -48'sh0000_8000_0000) sat_val = 32'sh8000_0000;
		else sat_val = acc_q[31:0];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (state_q == ST_DONE && out_free) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			result_value   <= bad_q ? 32'sd0 : sat_val;
			result_channel <= oc_q;
			result_row     <= row_q;
			result_col     <= col_q;
			status         <= bad_q;
		end
	end

	// checks
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |=> $stable(acc_q))
		else $error("accumulator changed while idle");
	a_s1_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(state_q == ST_RUN))
		else $error("tap issued outside run");
	a_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (!vld_s1 && !vld_s2))
		else $error("result taken before pipeline drained");
endmodule
